// ===== rtl/brlc_pkg.sv =====
// Shared types, constants and codes for the button repeat list cursor unit.
`default_nettype none

package brlc_pkg;

   localparam int SAMPLE_WIDTH     = 16;
   localparam int LANE_WIDTH       = $clog2(SAMPLE_WIDTH);
   localparam int HOLD_WIDTH       = 16;
   localparam int DELAY_WIDTH      = 16;
   localparam int PERIOD_WIDTH     = 8;
   localparam int LIST_WIDTH       = 8;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int NUM_BUTTONS_DEF  = 16;
   localparam int BTN_INDEX_WIDTH  = 5;

   localparam int MOD_WIDTH        = HOLD_WIDTH;
   localparam int MOD_STEP_BITS    = 4;
   localparam int MOD_CYCLES       = MOD_WIDTH / MOD_STEP_BITS;
   localparam int MOD_COUNT_WIDTH  = $clog2(MOD_CYCLES);

   localparam logic [HOLD_WIDTH-1:0]   HOLD_MAX      = 16'hFFFF;
   localparam logic [DELAY_WIDTH-1:0]  DELAY_RESET   = 16'd30;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET  = 8'd6;
   localparam logic [LIST_WIDTH-1:0]   COUNT_RESET   = 8'd0;
   localparam logic [LIST_WIDTH-1:0]   PAGE_RESET    = 8'd8;

   localparam int PAD_UP    = 0;
   localparam int PAD_DOWN  = 1;
   localparam int PAD_LEFT  = 2;
   localparam int PAD_RIGHT = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DELAY  = 2'd0,
      CSR_PERIOD = 2'd1,
      CSR_COUNT  = 2'd2,
      CSR_PAGE   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MOD,
      ST_CURSOR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    start;
      logic [MOD_WIDTH-1:0]    dividend;
      logic [PERIOD_WIDTH-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } mod_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/brlc_if.sv =====
// Valid/ready channel interfaces for the sample beat and the result beat.
`default_nettype none

interface brlc_req_if;
   logic                              valid;
   logic                              ready;
   logic [brlc_pkg::SAMPLE_WIDTH-1:0] buttons;

   modport source (output valid, output buttons, input ready);
   modport sink   (input valid, input buttons, output ready);
endinterface

interface brlc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [brlc_pkg::SAMPLE_WIDTH-1:0] pressed_mask;
   logic [brlc_pkg::SAMPLE_WIDTH-1:0] held_mask;
   logic [brlc_pkg::SAMPLE_WIDTH-1:0] repeat_mask;
   logic [brlc_pkg::LIST_WIDTH-1:0]   cursor;
   logic [brlc_pkg::LIST_WIDTH-1:0]   window_top;
   logic                              moved;

   modport source (output valid, output pressed_mask, output held_mask, output repeat_mask,
                   output cursor, output window_top, output moved, input ready);
   modport sink   (input valid, input pressed_mask, input held_mask, input repeat_mask,
                   input cursor, input window_top, input moved, output ready);
endinterface

`default_nettype wire

// ===== rtl/button_repeat_list_cursor_unit.sv =====
// Top level: button hold counters, typematic repeat and paged list cursor.
//
// One beat on req_bus carries a joypad sample for one frame; one beat on rsp_bus
// returns the rising-edge, held and repeat masks with the list cursor and window
// top after that frame. Exactly one result beat follows every sample beat.
// The block takes one sample at a time: req_bus.ready is high only while idle.
// After a sample beat the block scans the buttons in turn: each gets its hold
// counter update, and a pass through the shared remainder unit when its count
// has reached the initial delay. The cursor is updated after the scan, the
// result beat follows, and after the result beat the block returns to idle
// before the next sample is taken.
// The result holds on rsp_bus until rsp_bus.ready; no new sample is taken
// meanwhile. Configuration writes on the csr_ port take effect at the next
// edge. They are to be issued only while the block is idle; the user is bound
// by this, as the block itself does not enforce it. Writing the list count or
// the page size sends cursor and window top back to zero.
// Synchronous reset clears samples, hold counters, cursor and window, and loads
// the default delay, period, list count and page size.
`default_nettype none

module button_repeat_list_cursor_unit #(
   parameter int NUM_BUTTONS = brlc_pkg::NUM_BUTTONS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   brlc_req_if.sink                              req_bus,
   brlc_rsp_if.source                            rsp_bus,
   input  wire                                   csr_wr_en,
   input  wire [brlc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire [brlc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import brlc_pkg::*;

   localparam int IDXW = $clog2(NUM_BUTTONS);

   state_type                state_ff, state_in;
   logic [DELAY_WIDTH-1:0]   delay_ff;
   logic [PERIOD_WIDTH-1:0]  period_ff;
   logic [LIST_WIDTH-1:0]    count_ff;
   logic [LIST_WIDTH-1:0]    page_ff;
   logic [SAMPLE_WIDTH-1:0]  now_ff;
   logic [SAMPLE_WIDTH-1:0]  last_ff;
   logic [SAMPLE_WIDTH-1:0]  rep_ff;
   logic [HOLD_WIDTH-1:0]    hold_ff [NUM_BUTTONS];
   logic [IDXW-1:0]          idx_ff;
   logic [LIST_WIDTH-1:0]    cur_ff;
   logic [LIST_WIDTH-1:0]    top_ff;
   logic                     moved_ff;

   logic                     accept;
   logic [BTN_INDEX_WIDTH-1:0] idx_ext;
   logic                     in_lane;
   logic                     now_bit;
   logic                     idx_last;
   logic [HOLD_WIDTH-1:0]    cnt_cur;
   logic [HOLD_WIDTH-1:0]    cnt_new;
   logic                     need_mod;
   logic [SAMPLE_WIDTH-1:0]  pressed;
   logic [SAMPLE_WIDTH-1:0]  rep_all;
   logic [LIST_WIDTH-1:0]    cur_v;
   logic [LIST_WIDTH-1:0]    top_v;
   logic                     chg_v;
   mod_req_type              mod_req;
   mod_rsp_type              mod_rsp;

   brlc_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign accept   = req_bus.valid && req_bus.ready;
   assign idx_ext  = BTN_INDEX_WIDTH'(idx_ff);
   assign in_lane  = idx_ext < BTN_INDEX_WIDTH'(SAMPLE_WIDTH);
   assign now_bit  = in_lane && now_ff[idx_ext[LANE_WIDTH-1:0]];
   assign idx_last = (idx_ff == IDXW'(NUM_BUTTONS - 1));
   assign cnt_cur  = hold_ff[idx_ff];
   assign cnt_new  = !now_bit ? '0 : (cnt_cur == HOLD_MAX) ? cnt_cur : cnt_cur + 1'b1;
   assign need_mod = now_bit && (cnt_new >= delay_ff);
   assign pressed  = now_ff & ~last_ff;
   assign rep_all  = rep_ff | pressed;

   always_comb begin
      state_in         = state_ff;
      req_bus.ready    = (state_ff == ST_IDLE);
      rsp_bus.valid    = (state_ff == ST_DONE);
      mod_req.start    = 1'b0;
      mod_req.dividend = cnt_new - delay_ff;
      mod_req.divisor  = (period_ff == '0) ? PERIOD_WIDTH'(1) : period_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (need_mod) begin
               mod_req.start = 1'b1;
               state_in      = ST_MOD;
            end else if (idx_last) begin
               state_in = ST_CURSOR;
            end
         end
         ST_MOD: begin
            if (mod_rsp.done) begin
               state_in = idx_last ? ST_CURSOR : ST_LOAD;
            end
         end
         ST_CURSOR: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Apply down, up, page down and page up in that order on one cursor.
   always_comb begin
      logic [LIST_WIDTH-1:0] last_row;
      logic [LIST_WIDTH:0]   sum9;
      logic [LIST_WIDTH-1:0] tgt;
      last_row = count_ff - 1'b1;
      cur_v    = cur_ff;
      top_v    = top_ff;
      chg_v    = 1'b0;
      sum9     = '0;
      tgt      = '0;
      if (count_ff != '0) begin
         if (rep_all[PAD_DOWN] && (cur_v < last_row)) begin
            cur_v = cur_v + 1'b1;
            if ({1'b0, cur_v} >= ({1'b0, top_v} + {1'b0, page_ff})) begin
               top_v = (top_v == '1) ? top_v : top_v + 1'b1;
            end
            chg_v = 1'b1;
         end
         if (rep_all[PAD_UP] && (cur_v != '0)) begin
            cur_v = cur_v - 1'b1;
            if (cur_v < top_v) begin
               top_v = top_v - 1'b1;
            end
            chg_v = 1'b1;
         end
         if (pressed[PAD_RIGHT]) begin
            sum9 = {1'b0, cur_v} + {1'b0, page_ff};
            tgt  = (sum9 >= {1'b0, count_ff}) ? last_row : sum9[LIST_WIDTH-1:0];
            if (tgt != cur_v) begin
               cur_v = tgt;
               if ({1'b0, cur_v} >= ({1'b0, top_v} + {1'b0, page_ff})) begin
                  sum9  = {1'b0, cur_v} + 1'b1 - {1'b0, page_ff};
                  top_v = sum9[LIST_WIDTH] ? '1 : sum9[LIST_WIDTH-1:0];
               end
               chg_v = 1'b1;
            end
         end
         if (pressed[PAD_LEFT]) begin
            tgt = (cur_v >= page_ff) ? cur_v - page_ff : '0;
            if (tgt != cur_v) begin
               cur_v = tgt;
               if (cur_v < top_v) begin
                  top_v = cur_v;
               end
               chg_v = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DELAY_RESET;
         period_ff <= PERIOD_RESET;
         count_ff  <= COUNT_RESET;
         page_ff   <= PAGE_RESET;
         now_ff    <= '0;
         last_ff   <= '0;
         rep_ff    <= '0;
         idx_ff    <= '0;
         cur_ff    <= '0;
         top_ff    <= '0;
         moved_ff  <= 1'b0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            hold_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DELAY:  delay_ff <= csr_wdata[DELAY_WIDTH-1:0];
               CSR_PERIOD: period_ff <= csr_wdata[PERIOD_WIDTH-1:0];
               CSR_COUNT: begin
                  count_ff <= csr_wdata[LIST_WIDTH-1:0];
                  cur_ff   <= '0;
                  top_ff   <= '0;
               end
               CSR_PAGE: begin
                  page_ff <= csr_wdata[LIST_WIDTH-1:0];
                  cur_ff  <= '0;
                  top_ff  <= '0;
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            last_ff <= now_ff;
            now_ff  <= req_bus.buttons;
            rep_ff  <= '0;
            idx_ff  <= '0;
         end
         if (state_ff == ST_LOAD) begin
            hold_ff[idx_ff] <= cnt_new;
            if (!need_mod && !idx_last) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         if ((state_ff == ST_MOD) && mod_rsp.done) begin
            if (mod_rsp.rem_zero && in_lane) begin
               rep_ff[idx_ext[LANE_WIDTH-1:0]] <= 1'b1;
            end
            if (!idx_last) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         if (state_ff == ST_CURSOR) begin
            rep_ff   <= rep_all;
            cur_ff   <= cur_v;
            top_ff   <= top_v;
            moved_ff <= chg_v;
         end
      end
   end

   assign rsp_bus.pressed_mask = pressed;
   assign rsp_bus.held_mask    = now_ff;
   assign rsp_bus.repeat_mask  = rep_ff;
   assign rsp_bus.cursor       = cur_ff;
   assign rsp_bus.window_top   = top_ff;
   assign rsp_bus.moved        = moved_ff;

`ifndef SYNTH
   a_no_accept_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("sample taken while a result beat is pending");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (count_ff != '0)) |-> (cur_ff < count_ff))
      else $error("cursor beyond last list entry");

   a_mod_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == ST_MOD))
      else $error("remainder unit finished outside its wait state");

   a_repeat_has_press: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((pressed & ~rsp_bus.repeat_mask) == '0))
      else $error("rising edge missing from repeat mask");
`endif

endmodule

`default_nettype wire

// ===== rtl/brlc_mod.sv =====
// Shared iterative remainder unit, several restoring steps per cycle.
`default_nettype none

module brlc_mod (
   input  wire                  clock,
   input  wire                  reset,
   input  brlc_pkg::mod_req_type mod_req,
   output brlc_pkg::mod_rsp_type mod_rsp
);
   import brlc_pkg::*;

   logic                       busy_ff, busy_in;
   logic [MOD_COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [MOD_WIDTH-1:0]       quo_ff, quo_in;
   logic [PERIOD_WIDTH-1:0]    rem_ff, rem_in;
   logic [PERIOD_WIDTH-1:0]    div_ff, div_in;
   logic [MOD_WIDTH-1:0]       quo_step;
   logic [PERIOD_WIDTH-1:0]    rem_step;

   always_comb begin
      logic [PERIOD_WIDTH:0] trial;
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int k = 0; k < MOD_STEP_BITS; k++) begin
         trial = {rem_step, quo_step[MOD_WIDTH-1]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_step = trial[PERIOD_WIDTH-1:0];
         quo_step = {quo_step[MOD_WIDTH-2:0], 1'b0};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = mod_req.dividend;
         rem_in  = '0;
         div_in  = mod_req.divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         quo_in = quo_step;
         rem_in = rem_step;
         if (cnt_ff == MOD_COUNT_WIDTH'(MOD_CYCLES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   assign mod_rsp.done     = busy_ff && (cnt_ff == MOD_COUNT_WIDTH'(MOD_CYCLES - 1));
   assign mod_rsp.rem_zero = (rem_step == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

`default_nettype wire
